@@ hw/rtl/sacd_pkg.sv @@
`default_nettype none
package sacd_pkg;

    localparam int ADDR_W      = 32;
    localparam int WORD_BYTES  = 4;
    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_WORDS = 4;
    localparam int OFF_W       = $clog2(BLOCK_WORDS * WORD_BYTES);
    localparam int IDX_W       = $clog2(SETS);
    localparam int TAG_W       = ADDR_W - OFF_W - IDX_W;
    localparam int WAY_W       = $clog2(WAYS);
    localparam int CNT_W       = 32;
    localparam int PEN_W       = 8;

    localparam logic [PEN_W-1:0] PENALTY_RESET = 8'd4;

    typedef logic [IDX_W-1:0] t_set;
    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [WAY_W-1:0] t_way;
    typedef logic [CNT_W-1:0] t_cnt;

    // one directory row per set: tags, valid bits, order from lru to mru
    typedef struct packed {
        t_tag [WAYS-1:0]  tags;
        logic [WAYS-1:0]  valid;
        t_way [WAYS-1:0]  lru;
    } t_row;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic accept;
        logic update;
    } t_cmd;

endpackage
`default_nettype wire

@@ hw/rtl/sacd_ctrl.sv @@
`default_nettype none
module sacd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    output logic             o_busy,
    output sacd_pkg::t_cmd   o_cmd
);
    import sacd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.update = 1'b0;
        o_busy       = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // row read is back, compare and write in this cycle
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/sacd_datapath.sv @@
`default_nettype none
module sacd_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  sacd_pkg::t_cmd               i_cmd,
    input  wire [sacd_pkg::ADDR_W-1:0]   i_address,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [sacd_pkg::PEN_W-1:0]    i_miss_penalty,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [sacd_pkg::IDX_W-1:0]   o_set_idx,
    output logic [sacd_pkg::WAY_W-1:0]   o_way,
    output logic                         o_evicted,
    output logic [sacd_pkg::TAG_W-1:0]   o_evicted_tag,
    output logic [sacd_pkg::CNT_W-1:0]   o_access_count,
    output logic [sacd_pkg::CNT_W-1:0]   o_miss_count,
    output logic [sacd_pkg::CNT_W-1:0]   o_stall_total
);
    import sacd_pkg::*;

    t_row              r_mem [SETS];
    logic [SETS-1:0]   r_touched;
    t_row              r_rd_row;
    logic              r_seen;
    t_set              r_set;
    t_tag              r_tag;
    logic [PEN_W-1:0]  r_penalty;
    t_cnt              r_accesses;
    t_cnt              r_misses;
    t_cnt              r_stall;
    logic              r_valid;
    logic              r_hit;
    t_way              r_way;
    logic              r_evicted;
    t_tag              r_evicted_tag;

    t_set              in_set;
    t_row              row;
    t_row              n_row;
    logic [WAYS-1:0]   match;
    logic              hit;
    t_way              hit_way;
    t_way              way;
    logic [WAY_W-1:0]  pos;
    logic              evict;
    logic [CNT_W:0]    acc_sum;
    logic [CNT_W:0]    miss_sum;
    logic [CNT_W:0]    stall_sum;

    assign in_set      = i_address[OFF_W +: IDX_W];
    assign o_cfg_ready = 1'b1;

    // directory memory, one row per set
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_row <= r_mem[in_set];
            r_seen   <= r_touched[in_set];
            r_set    <= in_set;
            r_tag    <= i_address[ADDR_W-1 -: TAG_W];
        end
        if (i_cmd.update) begin
            r_mem[r_set] <= n_row;
        end
    end

    // sets never written read as empty with ways in index order
    always_comb begin
        row = r_rd_row;
        if (!r_seen) begin
            row.valid = '0;
            for (int w = 0; w < WAYS; w++) begin
                row.lru[w] = WAY_W'(w);
            end
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = row.valid[w] && (row.tags[w] == r_tag);
            if (match[w]) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        way = hit ? hit_way : row.lru[0];
        pos = '0;
        for (int p = 0; p < WAYS; p++) begin
            if (hit && row.lru[p] == hit_way) begin
                pos = WAY_W'(p);
            end
        end
        evict = !hit && row.valid[way];
        n_row = row;
        if (!hit) begin
            n_row.tags[way]  = r_tag;
            n_row.valid[way] = 1'b1;
        end
        // move the used way to the mru end
        for (int k = 0; k < WAYS - 1; k++) begin
            if (k >= int'(pos)) begin
                n_row.lru[k] = row.lru[k+1];
            end
        end
        n_row.lru[WAYS-1] = way;
    end

    assign acc_sum   = {1'b0, r_accesses} + (CNT_W+1)'(1);
    assign miss_sum  = {1'b0, r_misses} + (CNT_W+1)'(1);
    assign stall_sum = {1'b0, r_stall} + (CNT_W+1)'(r_penalty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched  <= '0;
            r_penalty  <= PENALTY_RESET;
            r_accesses <= '0;
            r_misses   <= '0;
            r_stall    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.update;
            if (i_cfg_valid && o_cfg_ready) begin
                r_penalty <= i_miss_penalty;
            end
            if (i_cmd.update) begin
                r_touched[r_set] <= 1'b1;
                r_accesses <= acc_sum[CNT_W] ? '1 : acc_sum[CNT_W-1:0];
                if (!hit) begin
                    r_misses <= miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
                    r_stall  <= stall_sum[CNT_W] ? '1 : stall_sum[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_hit         <= hit;
            r_way         <= way;
            r_evicted     <= evict;
            r_evicted_tag <= evict ? row.tags[way] : '0;
        end
    end

    assign o_valid        = r_valid;
    assign o_hit          = r_hit;
    assign o_set_idx      = r_set;
    assign o_way          = r_way;
    assign o_evicted      = r_evicted;
    assign o_evicted_tag  = r_evicted_tag;
    assign o_access_count = r_accesses;
    assign o_miss_count   = r_misses;
    assign o_stall_total  = r_stall;

`ifndef ASSERT_OFF
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe high on two cycles in a row");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> !o_evicted)
        else $error("eviction reported on a hit");

    a_evict_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted) |-> (o_evicted_tag == '0))
        else $error("evicted tag nonzero without eviction");

    a_miss_le_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_miss_count <= o_access_count)
        else $error("miss count above access count");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/set_assoc_lru_cache_directory_unit.sv @@
`default_nettype none
// set-associative tag directory with true lru replacement per set
//
// request: drive i_address with i_start high; the word is taken at an edge
// where o_busy is low. the directory is busy after that, while
// the set row is read and then compared, updated and written back.
// result: o_valid rises at the edge after the request edge and is high for
// exactly one cycle, so the result is taken at the edge that ends that cycle;
// it carries hit, set, way, eviction and the counters.
// the receiver cannot stall: the result must be taken in that cycle.
// a new request is taken only after the last one is written back: the set row
// is read when a request is taken, compared and written back in the next cycle.
// miss penalty: written via i_cfg_valid / o_cfg_ready (always ready); added to
// stall total per miss; write only while no request is in flight (unchecked).
// reset (i_rst_n low, synchronous): all sets empty with lru order way 0 first,
// counters zero, miss penalty 4. no clearing pass: per-set flags mark rows
// never written, so requests are taken from the first cycle after reset.
module set_assoc_lru_cache_directory_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire [sacd_pkg::ADDR_W-1:0]   i_address,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [sacd_pkg::PEN_W-1:0]    i_miss_penalty,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [sacd_pkg::IDX_W-1:0]   o_set_idx,
    output logic [sacd_pkg::WAY_W-1:0]   o_way,
    output logic                         o_evicted,
    output logic [sacd_pkg::TAG_W-1:0]   o_evicted_tag,
    output logic [sacd_pkg::CNT_W-1:0]   o_access_count,
    output logic [sacd_pkg::CNT_W-1:0]   o_miss_count,
    output logic [sacd_pkg::CNT_W-1:0]   o_stall_total
);
    import sacd_pkg::*;

    t_cmd cmd;

    sacd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    sacd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_address      (i_address),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_miss_penalty (i_miss_penalty),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_set_idx      (o_set_idx),
        .o_way          (o_way),
        .o_evicted      (o_evicted),
        .o_evicted_tag  (o_evicted_tag),
        .o_access_count (o_access_count),
        .o_miss_count   (o_miss_count),
        .o_stall_total  (o_stall_total)
    );

endmodule
`default_nettype wire
